/* rtl/mcsdc_pkg.sv */
package mcsdc_pkg;

  localparam int unsigned ADDR_W = 3;

  // register indexes
  localparam logic REG_MIN_YEAR = 1'b0;

  localparam logic [11:0] MIN_YEAR_RESET = 12'd2024;
  localparam logic [11:0] BASE_YEAR      = 12'd2000;

  // characters of the reply text
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;

  // format positions
  localparam logic [3:0] POS_CHAR = 4'd11;
  localparam logic [3:0] POS_ZONE = 4'd12;
  localparam logic [3:0] POS_DONE = 4'd13;

  // fields of one finished reply, numbers as two's complement bytes
  typedef struct packed {
    logic       base_ok;
    logic [7:0] yy;
    logic [7:0] mo;
    logic [7:0] dd;
    logic [7:0] hh;
    logic [7:0] mi;
    logic [7:0] ss;
    logic [7:0] tz;
  } snap_t;

  typedef struct packed {
    logic        time_valid;
    logic [11:0] full_year;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [7:0]  zone_quarters;
    logic [15:0] days_since_epoch;
  } res_t;

endpackage

/* rtl/modem_clock_string_to_day_count.sv */
// Modem clock reply parser.
// The slave stream carries the reply text one byte per item in s_tdata, with
// s_tlast on the final byte. Bytes up to the first double quote are skipped,
// then yy/mm/dd,hh:mm:ss<c><tz> is scanned as the bytes arrive.
// Each reply gives one result item on the master stream: m_tuser is the valid
// flag, m_tdata holds the date, time, zone in quarter hours and the day count
// since 2000-01-01; all of it is zero when the reply did not parse or failed a
// range check. The earliest accepted year is set through the APB register at
// address 0.
// Throughput is one byte per cycle while s_tready is high: the scan state
// updates in the cycle the byte is taken. After the last byte is taken the
// reply is held in the snapshot register, then the range checks and the day
// count go into the output register, which makes the result item valid.
// Reset clears the scan state and both stages and sets the minimum year to
// 2024. When m_tready is low, one finished reply waits in the output register
// and a second in the snapshot register; while both are held, s_tready is low
// and no byte is taken until the output register frees up.
module modem_clock_string_to_day_count (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // reply_byte
  input  logic        s_tlast,   // end_of_reply
  output logic        m_tvalid,
  input  logic        m_tready,
  // full_year[11:0], month_number[15:12], day_of_month[20:16], hour_of_day[25:21],
  // minute_of_hour[31:26], second_of_minute[37:32], zone_quarters[45:38],
  // days_since_epoch[61:46], zero fill[63:62]
  output logic [63:0] m_tdata,
  output logic [0:0]  m_tuser,   // time_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mcsdc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mcsdc_pkg::*;

  logic [11:0] minimum_year;
  logic        reg_index;
  logic        fire;
  logic        out_free;
  logic        snap_move;
  logic        snap_valid;
  snap_t       snap_cur;
  snap_t       snap;
  res_t        res;

  assign reg_index = paddr[ADDR_W-1];
  assign pready = 1'b1;
  assign prdata = (reg_index == REG_MIN_YEAR) ? {20'd0, minimum_year} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimum_year <= MIN_YEAR_RESET;
    end else if (psel && penable && pwrite && pready && (reg_index == REG_MIN_YEAR)) begin
      minimum_year <= pwdata[11:0];
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign snap_move = snap_valid && out_free;
  assign s_tready  = !snap_valid || out_free;
  assign fire      = s_tvalid && s_tready;

  mcsdc_scanner u_scanner (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .reply_byte   (s_tdata),
    .end_of_reply (s_tlast),
    .snap         (snap_cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (fire && s_tlast) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s_tlast) begin
      snap <= snap_cur;
    end
  end

  mcsdc_result u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (snap_move),
    .take         (m_tready),
    .snap         (snap),
    .minimum_year (minimum_year),
    .res_valid    (m_tvalid),
    .res          (res)
  );

  assign m_tuser = res.time_valid;
  assign m_tdata = {2'b00, res.days_since_epoch, res.zone_quarters, res.second_of_minute,
                    res.minute_of_hour, res.hour_of_day, res.day_of_month,
                    res.month_number, res.full_year};

endmodule

/* rtl/mcsdc_scanner.sv */
module mcsdc_scanner (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        reply_byte,
  input  logic              end_of_reply,
  output mcsdc_pkg::snap_t  snap
);
  import mcsdc_pkg::*;

  typedef struct packed {
    logic            quote_found;
    logic            scan_stopped;
    logic [3:0]      format_position;
    logic [1:0]      chars_in_field;
    logic            field_negative;
    logic            field_has_digit;
    logic [6:0]      field_accumulator;
    logic [3:0]      conversions_done;
    logic [6:0][7:0] parsed_fields;
    logic            minus_sign_char;
  } scan_t;

  localparam scan_t SCAN_CLEAR = '0;

  scan_t scan;
  scan_t scan_next;

  function automatic logic is_num(input logic [3:0] pos);
    return !pos[0] && (pos <= POS_ZONE);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [7:0] literal_at(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd1, 4'd3: c = CH_SLASH;
      4'd5:       c = CH_COMMA;
      4'd7, 4'd9: c = CH_COLON;
      default:    c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic scan_t finish_field(input scan_t s);
    scan_t r;
    logic [7:0] v;
    r = s;
    v = {1'b0, s.field_accumulator};
    if (s.field_negative) v = 8'(~v + 8'd1);
    r.parsed_fields[s.format_position[3:1]] = v;
    r.conversions_done  = s.conversions_done + 4'd1;
    r.format_position   = s.format_position + 4'd1;
    r.chars_in_field    = 2'd0;
    r.field_negative    = 1'b0;
    r.field_has_digit   = 1'b0;
    r.field_accumulator = 7'd0;
    return r;
  endfunction

  // separator, any-byte slot or end of format
  function automatic scan_t match_element(input scan_t s, input logic [7:0] b);
    scan_t r;
    r = s;
    if (s.format_position >= POS_DONE) begin
      r = s;
    end else if (s.format_position == POS_CHAR) begin
      r.minus_sign_char  = (b == CH_MINUS);
      r.conversions_done = s.conversions_done + 4'd1;
      r.format_position  = POS_ZONE;
    end else if (b == literal_at(s.format_position)) begin
      r.format_position = s.format_position + 4'd1;
    end else begin
      r.scan_stopped = 1'b1;
    end
    return r;
  endfunction

  scan_t s;
  scan_t f;

  always_comb begin
    s = scan;
    if (fire && !scan.scan_stopped) begin
      if (!s.quote_found) begin
        if (reply_byte == CH_NUL) s.scan_stopped = 1'b1;
        else if (reply_byte == CH_QUOTE) s.quote_found = 1'b1;
      end else if (reply_byte == CH_NUL) begin
        if (is_num(s.format_position) && s.field_has_digit) s = finish_field(s);
        s.scan_stopped = 1'b1;
      end else if (is_num(s.format_position)) begin
        if ((s.chars_in_field == 2'd0) && is_blank(reply_byte)) begin
          s = s;
        end else if ((s.chars_in_field == 2'd0) &&
                     ((reply_byte == CH_PLUS) || (reply_byte == CH_MINUS))) begin
          s.chars_in_field = 2'd1;
          s.field_negative = (reply_byte == CH_MINUS);
        end else if ((reply_byte >= CH_ZERO) && (reply_byte <= CH_NINE)) begin
          s.field_accumulator = 7'(({1'b0, s.field_accumulator} * 8'd10) +
                                   {4'd0, reply_byte[3:0]});
          s.field_has_digit = 1'b1;
          s.chars_in_field  = s.chars_in_field + 2'd1;
          if (s.chars_in_field == 2'd2) s = finish_field(s);
        end else if (s.field_has_digit) begin
          s = finish_field(s);
          s = match_element(s, reply_byte);
        end else begin
          s.scan_stopped = 1'b1;
        end
      end else begin
        s = match_element(s, reply_byte);
      end
    end

    // a pending number counts when the reply ends
    f = s;
    if (fire && end_of_reply && f.quote_found && !f.scan_stopped &&
        is_num(f.format_position) && f.field_has_digit) begin
      f = finish_field(f);
    end

    snap.base_ok = f.quote_found && (f.conversions_done >= 4'd6);
    snap.yy = f.parsed_fields[0];
    snap.mo = f.parsed_fields[1];
    snap.dd = f.parsed_fields[2];
    snap.hh = f.parsed_fields[3];
    snap.mi = f.parsed_fields[4];
    snap.ss = f.parsed_fields[5];
    snap.tz = f.minus_sign_char ? 8'(~f.parsed_fields[6] + 8'd1) : f.parsed_fields[6];

    scan_next = (fire && end_of_reply) ? SCAN_CLEAR : s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_CLEAR;
    end else begin
      scan <= scan_next;
    end
  end

endmodule

/* rtl/mcsdc_result.sv */
module mcsdc_result (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              take,
  input  mcsdc_pkg::snap_t  snap,
  input  logic [11:0]       minimum_year,
  output logic              res_valid,
  output mcsdc_pkg::res_t   res
);
  import mcsdc_pkg::*;

  function automatic logic [15:0] month_start(input logic [3:0] idx);
    logic [15:0] d;
    case (idx)
      4'd0:    d = 16'd0;
      4'd1:    d = 16'd31;
      4'd2:    d = 16'd59;
      4'd3:    d = 16'd90;
      4'd4:    d = 16'd120;
      4'd5:    d = 16'd151;
      4'd6:    d = 16'd181;
      4'd7:    d = 16'd212;
      4'd8:    d = 16'd243;
      4'd9:    d = 16'd273;
      4'd10:   d = 16'd304;
      4'd11:   d = 16'd334;
      default: d = 16'd0;
    endcase
    return d;
  endfunction

  logic [11:0]       year;
  logic signed [7:0] mo_s;
  logic signed [7:0] dd_s;
  logic signed [7:0] hh_s;
  logic signed [7:0] mi_s;
  logic signed [7:0] ss_s;
  logic              ok;
  logic [6:0]        n;
  logic [7:0]        n3;
  logic              leap_add;
  logic [15:0]       days;
  res_t              res_next;

  always_comb begin
    year = BASE_YEAR + {{4{snap.yy[7]}}, snap.yy};
    mo_s = $signed(snap.mo);
    dd_s = $signed(snap.dd);
    hh_s = $signed(snap.hh);
    mi_s = $signed(snap.mi);
    ss_s = $signed(snap.ss);
    ok = snap.base_ok && (year >= minimum_year) &&
         (mo_s >= 8'sd1) && (mo_s <= 8'sd12) && (dd_s >= 8'sd1) && (dd_s <= 8'sd31) &&
         (hh_s >= 8'sd0) && (hh_s <= 8'sd23) && (mi_s >= 8'sd0) && (mi_s <= 8'sd59) &&
         (ss_s >= 8'sd0) && (ss_s <= 8'sd59);

    // years since 2000, leap days before this year, this year's leap day
    n = snap.yy[6:0];
    n3 = {1'b0, n} + 8'd3;
    leap_add = (snap.mo[3:0] > 4'd2) && (n[1:0] == 2'd0);
    days = ({9'd0, n} * 16'd365) + {10'd0, n3[7:2]} +
           month_start(4'(snap.mo[3:0] - 4'd1)) + {15'd0, leap_add} +
           {11'd0, snap.dd[4:0]} - 16'd1;

    res_next = '0;
    if (ok) begin
      res_next.time_valid       = 1'b1;
      res_next.full_year        = year;
      res_next.month_number     = snap.mo[3:0];
      res_next.day_of_month     = snap.dd[4:0];
      res_next.hour_of_day      = snap.hh[4:0];
      res_next.minute_of_hour   = snap.mi[5:0];
      res_next.second_of_minute = snap.ss[5:0];
      res_next.zone_quarters    = snap.tz;
      res_next.days_since_epoch = snap.yy[7] ? 16'd0 : days;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import mcsdc_pkg::*;

  typedef enum logic [1:0] {EL_NUMBER, EL_LITERAL, EL_ANY, EL_END} element_t;

  localparam logic [ADDR_W-1:0] MIN_YEAR_ADDR = ADDR_W'({REG_MIN_YEAR, 2'b00});
  localparam logic [7:0] NUL_MARK = 8'h7e;
  localparam logic [7:0] CH_LF = 8'h0a;

  class clock_reply_board;
    res_t expected_stamps[$];
    int failures;
    logic [11:0] min_year;
    bit quote_seen, stopped, minus_char, negative, has_digit;
    int pos, n_chars, acc, n_conv;
    int fields[7];
    int month_offset[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function new();
      failures = 0;
      min_year = MIN_YEAR_RESET;
      clear_scan();
    endfunction

    function void clear_number();
      n_chars = 0;
      negative = 0;
      has_digit = 0;
      acc = 0;
    endfunction

    function void clear_scan();
      quote_seen = 0;
      stopped = 0;
      pos = 0;
      n_conv = 0;
      minus_char = 0;
      foreach (fields[i]) fields[i] = 0;
      clear_number();
    endfunction

    function element_t element_kind(int p);
      if (p >= POS_DONE) return EL_END;
      if (p == POS_CHAR) return EL_ANY;
      if (p % 2 == 0) return EL_NUMBER;
      return EL_LITERAL;
    endfunction

    function logic [7:0] separator(int p);
      if (p == 1 || p == 3) return CH_SLASH;
      if (p == 5) return CH_COMMA;
      return CH_COLON;
    endfunction

    function void finish_number();
      int v;
      v = negative ? -acc : acc;
      if (pos / 2 < 7) fields[pos / 2] = v;
      n_conv++;
      pos++;
      clear_number();
    endfunction

    // returns 0 when the byte must be looked at again by the next element
    function bit scan_char(logic [7:0] b);
      element_t k;
      if (b == CH_NUL) begin
        if (element_kind(pos) == EL_NUMBER && has_digit) finish_number();
        stopped = 1;
        return 1;
      end
      k = element_kind(pos);
      case (k)
        EL_END: return 1;
        EL_NUMBER: begin
          if (n_chars == 0 && (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) return 1;
          if (n_chars == 0 && (b == CH_PLUS || b == CH_MINUS)) begin
            n_chars = 1;
            negative = (b == CH_MINUS);
            return 1;
          end
          if (b >= CH_ZERO && b <= CH_NINE) begin
            acc = acc * 10 + int'(b - CH_ZERO);
            has_digit = 1;
            n_chars++;
            if (n_chars >= 2) finish_number();
            return 1;
          end
          if (has_digit) begin
            finish_number();
            return 0;
          end
          stopped = 1;
          return 1;
        end
        EL_ANY: begin
          minus_char = (b == CH_MINUS);
          n_conv++;
          pos = POS_ZONE;
          return 1;
        end
        default: begin
          if (b == separator(pos)) pos++;
          else stopped = 1;
          return 1;
        end
      endcase
    endfunction

    function int leaps_through(int y);
      return y / 4 - y / 100 + y / 400;
    endfunction

    function bit leap_year(int y);
      return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function void close_reply();
      res_t stamp;
      int year, tz, days;
      bit ok;
      if (quote_seen && !stopped && element_kind(pos) == EL_NUMBER && has_digit)
        finish_number();
      year = int'(BASE_YEAR) + fields[0];
      tz = minus_char ? -fields[6] : fields[6];
      ok = quote_seen && n_conv >= 6 && year >= int'(min_year) &&
           fields[1] >= 1 && fields[1] <= 12 && fields[2] >= 1 && fields[2] <= 31 &&
           fields[3] >= 0 && fields[3] <= 23 && fields[4] >= 0 && fields[4] <= 59 &&
           fields[5] >= 0 && fields[5] <= 59;
      stamp = '0;
      if (ok) begin
        days = 0;
        if (year >= int'(BASE_YEAR)) begin
          days = 365 * (year - 2000) + leaps_through(year - 1) - leaps_through(1999) +
                 month_offset[fields[1] - 1] + fields[2] - 1;
          if (fields[1] > 2 && leap_year(year)) days++;
        end
        stamp.time_valid = 1'b1;
        stamp.full_year = year[11:0];
        stamp.month_number = fields[1][3:0];
        stamp.day_of_month = fields[2][4:0];
        stamp.hour_of_day = fields[3][4:0];
        stamp.minute_of_hour = fields[4][5:0];
        stamp.second_of_minute = fields[5][5:0];
        stamp.zone_quarters = tz[7:0];
        stamp.days_since_epoch = days[15:0];
      end
      expected_stamps.push_back(stamp);
      clear_scan();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      if (!stopped) begin
        if (!quote_seen) begin
          if (b == CH_NUL) stopped = 1;
          else if (b == CH_QUOTE) quote_seen = 1;
        end else if (!scan_char(b)) begin
          void'(scan_char(b));
        end
      end
      if (last) close_reply();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_stamp(logic [63:0] d, logic flag);
      res_t want;
      if (expected_stamps.size() == 0) begin
        $display("%0t: unexpected item expected none got %h valid %b", $time, d, flag);
        failures++;
        return;
      end
      want = expected_stamps.pop_front();
      compare_field("time_valid", want.time_valid, flag);
      compare_field("full_year", want.full_year, d[11:0]);
      compare_field("month_number", want.month_number, d[15:12]);
      compare_field("day_of_month", want.day_of_month, d[20:16]);
      compare_field("hour_of_day", want.hour_of_day, d[25:21]);
      compare_field("minute_of_hour", want.minute_of_hour, d[31:26]);
      compare_field("second_of_minute", want.second_of_minute, d[37:32]);
      compare_field("zone_quarters", want.zone_quarters, d[45:38]);
      compare_field("days_since_epoch", want.days_since_epoch, d[61:46]);
      compare_field("zero fill", 16'd0, d[63:62]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 0;
  int stall_pct = 0;
  clock_reply_board board = new();

  string early_replies[20] = '{
    "+CCLK: \"24/01/01,00:00:00+00\"",
    "\"99/12/31,23:59:59-96\"",
    "\"23/06/15,10:20:30+08\"",
    "abc~\"24/01/01,00:00:00+00\"",
    "\"24/3/5,1:2:3",
    "\"24/03/05,01:02:3~9",
    "\"24/-/01,00:00:00+00\"",
    "\" 24/ 1/\t5, 3:04:05 +8\"",
    "\"24/03/05,01:02:03",
    "\"24-03-05,01:02:03+00\"",
    "\"24/13/05,01:02:03+00\"",
    "\"24/12/00,01:02:03+00\"",
    "\"24/12/31,24:00:00+00\"",
    "\"24/12/31,23:60:00+00\"",
    "\"24/12/31,23:59:60+00\"",
    "\"28/02/29,12:00:00--8\"",
    "\"+4/-1/05,01:02:03+00\"",
    "\"25/01/01,00:00:00+00\"xyz\r\n",
    "x",
    "~"
  };
  string old_year_replies[3] = '{
    "\"-5/06/07,08:09:10+04\"",
    "\"00/03/01,00:00:00+00\"",
    "\"-9/12/31,23:59:59-99\""
  };
  logic [11:0] phase_years[8];

  modem_clock_string_to_day_count uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_stamp(m_tdata, m_tuser[0]);
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    board.note_byte(b, last);
  endtask

  task automatic send_reply(input logic [7:0] text[$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.expected_stamps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min_year(input logic [11:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MIN_YEAR_ADDR;
    pwdata <= {20'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.min_year = v;
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {20'd0, v}) begin
      $display("%0t: minimum_year readback expected %0h got %0h", $time, v, prdata);
      board.failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void append_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i] == NUL_MARK ? CH_NUL : s[i]);
  endfunction

  function automatic void append_number(ref logic [7:0] q[$], input int lo, input int hi);
    int v, r;
    r = $urandom_range(0, 99);
    if (r < 4) q.push_back(r < 2 ? CH_SPACE : CH_TAB);
    v = ($urandom_range(0, 99) < 85) ? $urandom_range(hi, lo) : $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      q.push_back(CH_MINUS);
      q.push_back(8'(CH_ZERO + v % 10));
    end else if (r < 8) begin
      q.push_back(CH_PLUS);
      q.push_back(8'(CH_ZERO + v % 10));
    end else if (v < 10 && r < 25) begin
      q.push_back(8'(CH_ZERO + v));
    end else begin
      q.push_back(8'(CH_ZERO + v / 10));
      q.push_back(8'(CH_ZERO + v % 10));
    end
  endfunction

  function automatic void append_sep(ref logic [7:0] q[$], input logic [7:0] c);
    q.push_back(($urandom_range(0, 99) < 3) ? 8'($urandom_range(0, 255)) : c);
  endfunction

  function automatic void build_reply(ref logic [7:0] q[$], input int low_yy);
    int r, at;
    q.delete();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      repeat ($urandom_range(1, 30)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 70) append_text(q, "+CCLK: ");
    else if (r < 85) repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 95) q.push_back(CH_QUOTE);
    append_number(q, low_yy, 99);
    append_sep(q, CH_SLASH);
    append_number(q, 1, 12);
    append_sep(q, CH_SLASH);
    append_number(q, 1, 31);
    append_sep(q, CH_COMMA);
    append_number(q, 0, 23);
    append_sep(q, CH_COLON);
    append_number(q, 0, 59);
    append_sep(q, CH_COLON);
    append_number(q, 0, 59);
    r = $urandom_range(0, 99);
    if (r < 12) return;
    q.push_back(r < 55 ? CH_PLUS : (r < 92 ? CH_MINUS : 8'($urandom_range(0, 255))));
    append_number(q, 0, 99);
    if ($urandom_range(0, 99) < 70) q.push_back(CH_QUOTE);
    if ($urandom_range(0, 99) < 30) begin
      q.push_back(CH_CR);
      q.push_back(CH_LF);
    end
    r = $urandom_range(0, 99);
    at = $urandom_range(0, q.size() - 1);
    if (r < 10) q[at] = 8'($urandom_range(0, 255));
    else if (r < 15) q.insert(at, CH_NUL);
    else if (r < 20) while (q.size() > at + 1) void'(q.pop_back());
  endfunction

  initial begin
    logic [7:0] text[$];
    int sent, low_yy;
    phase_years = '{12'd2000, 12'd2099, 12'd1950, 12'($urandom_range(2000, 2099)),
                    12'd0, 12'd2024, 12'($urandom_range(2000, 2099)), 12'd2000};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (early_replies[i]) begin
      text.delete();
      append_text(text, early_replies[i]);
      send_reply(text);
    end
    wait_idle();
    write_min_year(12'd1901);
    foreach (old_year_replies[i]) begin
      text.delete();
      append_text(text, old_year_replies[i]);
      send_reply(text);
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_min_year(phase_years[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      if (phase_years[ph] < BASE_YEAR) low_yy = 0;
      else if (phase_years[ph] - BASE_YEAR > 99) low_yy = 99;
      else low_yy = int'(phase_years[ph] - BASE_YEAR);
      sent = 0;
      while (sent < 135) begin
        build_reply(text, low_yy);
        send_reply(text);
        sent += text.size();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (board.failures == 0) begin
      $display("modem_clock_string_to_day_count test passed");
    end else begin
      $display("modem_clock_string_to_day_count test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("modem_clock_string_to_day_count test failed");
    $finish;
  end

endmodule
